// ===== rtl/u8sf_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sf_pkg
// Constants and types for the utf-8 structure filter.
// ----------------------------------------------------------------------------
package u8sf_pkg;

  localparam int unsigned HeldDepth = 3;
  localparam int unsigned MaxOut    = 4;

  localparam logic [7:0] ByteNul    = 8'h00;
  localparam logic [7:0] MaskTop2   = 8'hC0;
  localparam logic [7:0] MaskTop3   = 8'hE0;
  localparam logic [7:0] MaskTop4   = 8'hF0;
  localparam logic [7:0] MaskTop5   = 8'hF8;
  localparam logic [7:0] PatCont    = 8'h80;
  localparam logic [7:0] PatLead2   = 8'hC0;
  localparam logic [7:0] PatLead3   = 8'hE0;
  localparam logic [7:0] PatLead4   = 8'hF0;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] need_t;
  typedef logic [1:0] held_cnt_t;
  typedef logic [2:0] out_cnt_t;

endpackage

// ===== rtl/utf8_structure_filter.sv =====
// ----------------------------------------------------------------------------
// utf8_structure_filter
// Passes well-formed utf-8 structure of a byte stream, holding multi-byte
// sequences until complete and dropping nul, stray and broken bytes.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------
//   input   | in_valid/in_ready  | in_byte, text_last
//   output  | out_valid/out_ready| out_byte, run_last
//
// Each input item is decoded combinationally; its 0 to 4 result bytes are
// loaded into a 4-byte output shift buffer and leave one per cycle while
// out_ready is high, so an item yielding at most one byte then sustains one
// item per cycle; a completed n-byte sequence holds the output until taken.
// in_ready is high while the buffer is empty or its last byte is being taken.
// Synchronous reset clears the sequence state and empties the buffer.
// ----------------------------------------------------------------------------
module utf8_structure_filter
  import u8sf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_byte,
  input  logic text_last,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] out_byte,
  output logic run_last
);

  need_t     bytes_needed, bytes_needed_next;
  held_cnt_t held_count, held_count_next;
  byte_t     held_bytes [HeldDepth];
  logic      held_we;

  byte_t     obuf [MaxOut];
  out_cnt_t  ocnt;

  byte_t     res [MaxOut];
  out_cnt_t  res_cnt;

  logic      in_acc, out_take, is_cont, fresh;
  need_t     need_dec;

  assign out_valid = (ocnt != '0);
  assign out_take  = out_valid && out_ready;
  assign in_ready  = (ocnt == '0) || ((ocnt == out_cnt_t'(1)) && out_ready);
  assign in_acc    = in_valid && in_ready;
  assign out_byte  = obuf[0];
  assign run_last  = (ocnt == out_cnt_t'(1));

  assign is_cont  = ((in_byte & MaskTop2) == PatCont);
  assign need_dec = bytes_needed - need_t'(1);

  // result slots for a completed sequence: held bytes then the current byte
  always_comb begin
    for (int i = 0; i < HeldDepth; i++) begin
      res[i] = (held_cnt_t'(i) < held_count) ? held_bytes[i] : in_byte;
    end
    res[MaxOut-1] = in_byte;
  end

  always_comb begin
    bytes_needed_next = bytes_needed;
    held_count_next   = held_count;
    held_we           = 1'b0;
    res_cnt           = '0;
    fresh             = 1'b1;

    if (bytes_needed != '0) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (need_dec == '0) begin
          res_cnt           = out_cnt_t'(held_count) + out_cnt_t'(1);
          bytes_needed_next = '0;
          held_count_next   = '0;
        end else begin
          bytes_needed_next = need_dec;
          if (held_count < held_cnt_t'(HeldDepth)) begin
            held_we         = 1'b1;
            held_count_next = held_count + held_cnt_t'(1);
          end
        end
      end else begin
        bytes_needed_next = '0;
        held_count_next   = '0;
      end
    end

    if (fresh) begin
      if (in_byte == ByteNul) begin
        res_cnt = '0;
      end else if (in_byte[7] == 1'b0) begin
        res_cnt = out_cnt_t'(1);
      end else if ((in_byte & MaskTop3) == PatLead2) begin
        held_we           = 1'b1;
        held_count_next   = held_cnt_t'(1);
        bytes_needed_next = need_t'(1);
      end else if ((in_byte & MaskTop4) == PatLead3) begin
        held_we           = 1'b1;
        held_count_next   = held_cnt_t'(1);
        bytes_needed_next = need_t'(2);
      end else if ((in_byte & MaskTop5) == PatLead4) begin
        held_we           = 1'b1;
        held_count_next   = held_cnt_t'(1);
        bytes_needed_next = need_t'(3);
      end
    end

    if (text_last) begin
      bytes_needed_next = '0;
      held_count_next   = '0;
    end
  end

  // a fresh lead byte lands in entry 0, a continuation at held_count
  always_ff @(posedge clk) begin
    if (in_acc && held_we) begin
      if (fresh) begin
        held_bytes[0] <= in_byte;
      end else begin
        held_bytes[held_count] <= in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_needed <= '0;
      held_count   <= '0;
    end else if (in_acc) begin
      bytes_needed <= bytes_needed_next;
      held_count   <= held_count_next;
    end
  end

  // output shift buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else if (in_acc) begin
      ocnt <= res_cnt;
    end else if (out_take) begin
      ocnt <= ocnt - out_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (fresh) begin
        obuf[0] <= in_byte;
      end else begin
        for (int i = 0; i < MaxOut; i++) begin
          obuf[i] <= res[i];
        end
      end
    end else if (out_take) begin
      for (int i = 0; i < MaxOut - 1; i++) begin
        obuf[i] <= obuf[i+1];
      end
    end
  end

endmodule

// ===== verif/u8sf_stream_check.sv =====
// ----------------------------------------------------------------------------
// u8sf_stream_check
// Watches both channels of the utf-8 structure filter. Each accepted input
// item is run through a local model of the sequence state, and the bytes it
// should release are queued; each accepted output item is compared with the
// oldest queued byte. Mismatch and pending counts go back to the top.
// ----------------------------------------------------------------------------
module u8sf_stream_check
  import u8sf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [7:0] in_byte,
  input  logic text_last,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [7:0] out_byte,
  input  logic run_last,
  output int unsigned mismatches,
  output int unsigned awaiting
);

  typedef struct packed {
    byte_t data;
    logic  tail;
  } released_t;

  released_t released_q[$];
  need_t     seq_need;
  held_cnt_t seq_held;
  byte_t     seq_bytes [HeldDepth];

  initial begin
    mismatches = 0;
    awaiting = 0;
    seq_need = '0;
    seq_held = '0;
  end

  task automatic filter_byte(input byte_t b, input logic fin);
    byte_t     got [MaxOut];
    int        n;
    logic      fresh;
    need_t     lead_need;
    released_t r;
    n = 0;
    fresh = 1'b1;
    lead_need = '0;
    if (seq_need != '0) begin
      if ((b & MaskTop2) == PatCont) begin
        fresh = 1'b0;
        seq_need = seq_need - 2'd1;
        if (seq_need == '0) begin
          for (int i = 0; i < int'(seq_held) && i < int'(HeldDepth); i++) begin
            got[n] = seq_bytes[i];
            n++;
          end
          got[n] = b;
          n++;
          seq_held = '0;
        end else if (seq_held < HeldDepth) begin
          seq_bytes[seq_held] = b;
          seq_held = seq_held + 2'd1;
        end
      end else begin
        seq_need = '0;
        seq_held = '0;
      end
    end
    if (fresh) begin
      if (b == ByteNul) begin
        // nul dropped
      end else if (!b[7]) begin
        got[n] = b;
        n++;
      end else if ((b & MaskTop3) == PatLead2) begin
        lead_need = 2'd1;
      end else if ((b & MaskTop4) == PatLead3) begin
        lead_need = 2'd2;
      end else if ((b & MaskTop5) == PatLead4) begin
        lead_need = 2'd3;
      end
      if (lead_need != '0) begin
        seq_bytes[0] = b;
        seq_held = 2'd1;
        seq_need = lead_need;
      end
    end
    if (fin) begin
      seq_need = '0;
      seq_held = '0;
    end
    for (int k = 0; k < n; k++) begin
      r.data = got[k];
      r.tail = (k == n - 1);
      released_q = {released_q, r};
    end
  endtask

  always @(posedge clk) begin
    released_t want;
    if (rst) begin
      seq_need = '0;
      seq_held = '0;
      released_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (released_q.size() == 0) begin
          $display("%0t: no item expected, got out_byte %02h run_last %0b",
                   $time, out_byte, run_last);
          mismatches++;
        end else begin
          want = released_q.pop_front();
          if (want.data !== out_byte) begin
            $display("%0t: out_byte expected %02h, got %02h",
                     $time, want.data, out_byte);
            mismatches++;
          end
          if (want.tail !== run_last) begin
            $display("%0t: run_last expected %0b, got %0b",
                     $time, want.tail, run_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        filter_byte(in_byte, text_last);
      end
    end
    awaiting = released_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the utf-8 structure filter with a directed set of byte patterns
// (ascii, nul, complete, broken and cut-off multi-byte sequences, stray
// bytes) followed by random texts made mostly of well-formed sequences.
// Both channels idle at random; the stream checker does the comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import u8sf_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned TotalItems  = 170;
  localparam int unsigned DrainCycles = 16;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_byte;
  logic text_last;
  logic out_valid;
  logic out_ready;
  logic [7:0] out_byte;
  logic run_last;

  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned cycles;
  int unsigned sent;
  logic calm;

  utf8_structure_filter dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .text_last(text_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .run_last(run_last)
  );

  u8sf_stream_check checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .text_last(text_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .run_last(run_last),
    .mismatches(mismatches),
    .awaiting(awaiting)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // wait length for one item, zero during calm stretches
  function automatic int unsigned pick_wait();
    if ($urandom_range(0, 15) == 0) begin
      calm = ~calm;
    end
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic send_byte(input byte_t b, input logic fin);
    int unsigned gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    text_last <= fin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic rand_last();
    return ($urandom_range(0, 11) == 0);
  endfunction

  function automatic byte_t rand_cont();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // lead for a sequence of len bytes, len 1 gives a non-nul ascii byte
  function automatic byte_t rand_lead(input int len);
    case (len)
      1: return 8'($urandom_range(1, 127));
      2: return {3'b110, 5'($urandom_range(0, 31))};
      3: return {4'b1110, 4'($urandom_range(0, 15))};
      default: return {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  task automatic send_seq(input int len, input logic cut);
    int conts;
    conts = cut ? $urandom_range(0, len - 2) : len - 1;
    send_byte(rand_lead(len), rand_last());
    for (int i = 0; i < conts; i++) begin
      send_byte(rand_cont(), rand_last());
    end
  endtask

  initial begin
    int unsigned pick;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = '0;
    text_last = 1'b0;
    cycles = 0;
    sent = 0;
    calm = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ascii extremes and nul
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    // complete 2, 3 and 4 byte sequences
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'hBF, 1'b1);
    // stray continuations and bytes f8..ff
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b0);
    // broken by ascii, by a new lead, by nul
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h00, 1'b0);
    // end of text mid sequence and on a fresh lead
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'hC3, 1'b1);
    send_byte(8'hA9, 1'b0);

    while (sent < TotalItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_seq(1, 1'b0);
      end else if (pick < 30) begin
        send_seq(2, 1'b0);
      end else if (pick < 50) begin
        send_seq(3, 1'b0);
      end else if (pick < 70) begin
        send_seq(4, 1'b0);
      end else if (pick < 85) begin
        send_seq($urandom_range(2, 4), 1'b1);
      end else begin
        send_byte(8'($urandom_range(0, 255)), rand_last());
      end
    end

    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

endmodule
